[hdl/rsym_pkg.sv]
// Shared types, constants and a helper function for the signed integer to
// radix symbols block. Has no dependencies; every other file uses it.
package rsym_pkg;

  // Input and output widths.
  localparam int MAG_W = 32;
  localparam int SYM_W = 8;

  // Configuration port.
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int BASE_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN   = 2'd2;

  // Alphabet layout.
  localparam int NUM_SYMBOLS  = 16;
  localparam int SYM_IDX_W    = $clog2(NUM_SYMBOLS);
  localparam int MAX_BASE_DEF = 16;

  localparam logic [SYM_W-1:0]  SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0]  SYM_PLUS  = 8'h2B;
  localparam logic [BASE_W-1:0] MIN_BASE  = 5'd2;

  // Divider chain: one cell per possible digit.
  localparam int NUM_CELLS  = 32;
  localparam int PTR_W      = $clog2(NUM_CELLS);
  localparam int RUN_CYCLES = MAG_W + NUM_CELLS - 1;
  localparam int CNT_W      = $clog2(RUN_CYCLES + 1);

  // One quotient bit handed from a cell to its neighbor.
  typedef struct packed {
    logic v;
    logic q;
  } rsym_link_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIND,
    ST_SIGN,
    ST_EMIT
  } rsym_state_t;

  // Returns alphabet symbol idx; symbols 0 to 7 live in the low word.
  function automatic logic [SYM_W-1:0] symbol_at(
    input logic [CFG_W-1:0]     alpha_low,
    input logic [CFG_W-1:0]     alpha_high,
    input logic [SYM_IDX_W-1:0] idx
  );
    logic [2*CFG_W-1:0] both;
    both = {alpha_high, alpha_low};
    return both[idx*SYM_W +: SYM_W];
  endfunction

endpackage

[hdl/signed_integer_to_radix_symbols_top.sv]
// Signed integer to radix symbols, top level. Depends on rsym_pkg, rsym_cell
// and rsym_alpha_check.
// An item holds the input while it sweeps through the divider chain, while its
// top digit is found, and while its optional minus sign and its digits, 1 to 32
// of them, are emitted. Synchronous active-high reset clears control state and
// the configuration registers.
module signed_integer_to_radix_symbols_top #(
  parameter int MAX_BASE = rsym_pkg::MAX_BASE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write port.
  input  logic                           cfg_write,
  input  logic [rsym_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsym_pkg::CFG_W-1:0]     cfg_data,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [rsym_pkg::MAG_W-1:0] number,
  // Output channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rsym_pkg::SYM_W-1:0]     symbol,
  output logic                           last
);

  localparam int RW = $clog2(MAX_BASE);

  // Configuration registers.
  logic [rsym_pkg::CFG_W-1:0]  alpha_low;
  logic [rsym_pkg::CFG_W-1:0]  alpha_high;
  logic [rsym_pkg::BASE_W-1:0] base_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_low   <= '0;
      alpha_high  <= '0;
      base_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rsym_pkg::REG_ALPHA_LOW:  alpha_low   <= cfg_data;
        rsym_pkg::REG_ALPHA_HIGH: alpha_high  <= cfg_data;
        rsym_pkg::REG_BASE_LEN:   base_length <= cfg_data[rsym_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // The alphabet check is registered every cycle. It is only consulted after
  // the divider sweep, long after any configuration write made while idle has settled.
  logic alpha_ok_comb;
  logic alpha_ok;

  rsym_alpha_check #(
    .MAX_BASE (MAX_BASE)
  ) u_alpha_check (
    .alpha_low   (alpha_low),
    .alpha_high  (alpha_high),
    .base_length (base_length),
    .ok          (alpha_ok_comb)
  );

  always_ff @(posedge clk) begin
    alpha_ok <= alpha_ok_comb;
  end

  // Control and payload registers.
  rsym_pkg::rsym_state_t      state, state_next;
  logic [rsym_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [rsym_pkg::MAG_W-1:0] mag, mag_next;
  logic                       neg, neg_next;
  logic [rsym_pkg::PTR_W-1:0] ptr, ptr_next;
  logic                       out_valid_next;
  logic [rsym_pkg::SYM_W-1:0] symbol_next;
  logic                       last_next;

  // Divider chain. The magnitude enters cell 0 most significant bit first;
  // each cell divides the stream it sees by the radix and hands its quotient
  // bits on, so cell k ends up holding digit k as its remainder. A cell's
  // seen flag tells whether its dividend was nonzero, i.e. whether digit k
  // exists (digit 0 always does).
  rsym_pkg::rsym_link_t links [rsym_pkg::NUM_CELLS+1];
  logic [RW-1:0]        rems  [rsym_pkg::NUM_CELLS];
  logic [rsym_pkg::NUM_CELLS-1:0] seen;
  logic                 cells_clr;

  assign links[0].v = (state == rsym_pkg::ST_RUN) &&
                      (cnt < rsym_pkg::CNT_W'(rsym_pkg::MAG_W));
  assign links[0].q = mag[rsym_pkg::MAG_W-1];

  for (genvar k = 0; k < rsym_pkg::NUM_CELLS; k++) begin : g_cell
    rsym_cell #(
      .MAX_BASE (MAX_BASE)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (cells_clr),
      .radix    ((RW+1)'(base_length)),
      .link_in  (links[k]),
      .link_out (links[k+1]),
      .rem      (rems[k]),
      .seen     (seen[k])
    );
  end

  // The seen flags form a run of ones from cell 0 upward. The top digit sits
  // where that run ends; with no ones above cell 0 the number has a single digit.
  logic [rsym_pkg::NUM_CELLS:0]   seen_ext;
  logic [rsym_pkg::PTR_W-1:0]     top_digit;

  always_comb begin
    seen_ext  = {1'b0, seen};
    top_digit = '0;
    for (int k = 1; k < rsym_pkg::NUM_CELLS; k++) begin
      if (seen_ext[k] && !seen_ext[k+1]) begin
        top_digit = top_digit | rsym_pkg::PTR_W'(k);
      end
    end
  end

  // The output register frees up when it is empty or its item is taken.
  logic out_free;
  logic [rsym_pkg::SYM_IDX_W-1:0] digit;

  assign out_free = !out_valid || !out_stall;
  assign digit    = rsym_pkg::SYM_IDX_W'(rems[ptr]);
  assign in_stall = (state != rsym_pkg::ST_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    mag_next       = mag;
    neg_next       = neg;
    ptr_next       = ptr;
    out_valid_next = out_valid && out_stall;
    symbol_next    = symbol;
    last_next      = last;
    cells_clr      = 1'b0;

    case (state)
      rsym_pkg::ST_IDLE: begin
        if (in_valid) begin
          // Two's complement negate gives the 33-bit magnitude's low 32
          // bits, which is enough since the magnitude never exceeds 2^31.
          neg_next   = number[rsym_pkg::MAG_W-1];
          mag_next   = number[rsym_pkg::MAG_W-1] ? (~number + 1'b1) : number;
          cnt_next   = '0;
          cells_clr  = 1'b1;
          state_next = rsym_pkg::ST_RUN;
        end
      end

      rsym_pkg::ST_RUN: begin
        mag_next = {mag[rsym_pkg::MAG_W-2:0], 1'b0};
        cnt_next = cnt + 1'b1;
        if (cnt == rsym_pkg::CNT_W'(rsym_pkg::RUN_CYCLES - 1)) begin
          state_next = rsym_pkg::ST_FIND;
        end
      end

      rsym_pkg::ST_FIND: begin
        ptr_next = top_digit;
        if (!alpha_ok) begin
          state_next = rsym_pkg::ST_IDLE;
        end else if (neg) begin
          state_next = rsym_pkg::ST_SIGN;
        end else begin
          state_next = rsym_pkg::ST_EMIT;
        end
      end

      rsym_pkg::ST_SIGN: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          symbol_next    = rsym_pkg::SYM_MINUS;
          last_next      = 1'b0;
          state_next     = rsym_pkg::ST_EMIT;
        end
      end

      rsym_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          symbol_next    = rsym_pkg::symbol_at(alpha_low, alpha_high, digit);
          last_next      = (ptr == '0);
          if (ptr == '0) begin
            state_next = rsym_pkg::ST_IDLE;
          end else begin
            ptr_next = ptr - 1'b1;
          end
        end
      end

      default: begin
        state_next = rsym_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rsym_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mag    <= mag_next;
    neg    <= neg_next;
    ptr    <= ptr_next;
    symbol <= symbol_next;
    last   <= last_next;
  end

endmodule

[hdl/rsym_cell.sv]
// One cell of the systolic divider chain: a single restoring division step
// by the radix per incoming dividend bit. Depends on rsym_pkg.
module rsym_cell #(
  parameter int MAX_BASE = rsym_pkg::MAX_BASE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clr,
  input  logic [$clog2(MAX_BASE):0]         radix,
  input  rsym_pkg::rsym_link_t              link_in,
  output rsym_pkg::rsym_link_t              link_out,
  output logic [$clog2(MAX_BASE)-1:0]       rem,
  output logic                              seen
);

  localparam int RW = $clog2(MAX_BASE);

  logic [RW:0] trial;
  logic [RW:0] diff;
  logic        ge;

  assign trial = {rem, link_in.q};
  assign ge    = (trial >= radix);
  assign diff  = trial - radix;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      link_out <= '0;
      rem      <= '0;
      seen     <= 1'b0;
    end else begin
      link_out.v <= link_in.v;
      if (link_in.v) begin
        link_out.q <= ge;
        rem        <= ge ? diff[RW-1:0] : trial[RW-1:0];
        seen       <= seen | link_in.q;
      end
    end
  end

endmodule

[hdl/rsym_alpha_check.sv]
// Validity check of the configured alphabet: length in range, no sign
// symbols and no duplicates among the symbols in use. Depends on rsym_pkg.
module rsym_alpha_check #(
  parameter int MAX_BASE = rsym_pkg::MAX_BASE_DEF
) (
  input  logic [rsym_pkg::CFG_W-1:0]  alpha_low,
  input  logic [rsym_pkg::CFG_W-1:0]  alpha_high,
  input  logic [rsym_pkg::BASE_W-1:0] base_length,
  output logic                        ok
);

  logic [rsym_pkg::SYM_W-1:0] syms [rsym_pkg::NUM_SYMBOLS];
  logic                       used [rsym_pkg::NUM_SYMBOLS];

  always_comb begin
    logic bad;
    bad = (base_length < rsym_pkg::MIN_BASE) ||
          (base_length > rsym_pkg::BASE_W'(MAX_BASE));
    for (int i = 0; i < rsym_pkg::NUM_SYMBOLS; i++) begin
      syms[i] = rsym_pkg::symbol_at(alpha_low, alpha_high, rsym_pkg::SYM_IDX_W'(i));
      used[i] = (rsym_pkg::BASE_W'(i) < base_length);
    end
    for (int i = 0; i < rsym_pkg::NUM_SYMBOLS; i++) begin
      if (used[i] && (syms[i] == rsym_pkg::SYM_MINUS || syms[i] == rsym_pkg::SYM_PLUS)) begin
        bad = 1'b1;
      end
      for (int j = i + 1; j < rsym_pkg::NUM_SYMBOLS; j++) begin
        if (used[j] && syms[i] == syms[j]) begin
          bad = 1'b1;
        end
      end
    end
    ok = !bad;
  end

endmodule

[tb/tb_signed_integer_to_radix_symbols_top.sv]
// Self-checking testbench for signed_integer_to_radix_symbols_top, the block that
// spells signed numbers as symbol runs in a configured radix. Depends on rsym_pkg
// for widths and register indexes, and on the top-level RTL.
module tb_signed_integer_to_radix_symbols_top;

  // Index 3 is not a register; writes to it must leave the alphabet untouched.
  localparam logic [rsym_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // The slowest item holds the input for the divider sweep, a minus and 32 digits,
  // so this many idle cycles after the last symbol guarantee the block has gone quiet.
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 500000;

  // One emitted byte of a run, as the output channel presents it.
  typedef struct packed {
    logic [rsym_pkg::SYM_W-1:0] symbol;
    logic                       last;
  } sym_beat_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [rsym_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rsym_pkg::CFG_W-1:0]     cfg_data  = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  logic [rsym_pkg::MAG_W-1:0]     number    = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [rsym_pkg::SYM_W-1:0]     symbol;
  logic                           last;

  // Our own copy of the configuration, updated as each register is written.
  logic [rsym_pkg::CFG_W-1:0]  alpha_lo = '0;
  logic [rsym_pkg::CFG_W-1:0]  alpha_hi = '0;
  logic [rsym_pkg::BASE_W-1:0] base_len = '0;

  // Symbols predicted for accepted items and not yet seen on the output.
  sym_beat_t owed_symbols[$];

  // When set, neither side idles: the sender offers items back to back and
  // the output is never stalled.
  bit calm = 1'b0;

  int fail_count      = 0;
  int numbers_sent    = 0;
  int symbols_checked = 0;
  int settings_used   = 0;
  int cycle_count     = 0;

  signed_integer_to_radix_symbols_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .number    (number),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .last      (last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // The receiver stalls at random, about 18 percent of the time, unless calm.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 18);
  end

  // Byte idx of the configured alphabet; symbols 8 to 15 sit in the high word.
  function automatic logic [rsym_pkg::SYM_W-1:0] alpha_byte(input logic [3:0] idx);
    logic [rsym_pkg::CFG_W-1:0] word;
    word = idx[3] ? alpha_hi : alpha_lo;
    return word[idx[2:0]*rsym_pkg::SYM_W +: rsym_pkg::SYM_W];
  endfunction

  // The alphabet is usable when its length is a legal radix and the symbols
  // in use are distinct and contain no sign character. Bytes beyond the
  // length do not matter.
  function automatic bit alphabet_usable();
    logic [rsym_pkg::SYM_W-1:0] a;
    if (base_len < rsym_pkg::MIN_BASE || base_len > rsym_pkg::MAX_BASE_DEF) return 1'b0;
    for (int i = 0; i < base_len; i++) begin
      a = alpha_byte(i[3:0]);
      if (a == rsym_pkg::SYM_MINUS || a == rsym_pkg::SYM_PLUS) return 1'b0;
      for (int j = i + 1; j < base_len; j++) begin
        if (a == alpha_byte(j[3:0])) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Queues the run that one number should produce: an optional minus byte,
  // then the digits of the magnitude, most significant first. The magnitude
  // is taken as unsigned, so the most negative number needs no special path.
  function automatic void predict_symbols(input logic [rsym_pkg::MAG_W-1:0] value);
    logic [rsym_pkg::MAG_W-1:0] mag;
    logic [3:0]                 digits [32];
    int                         count;
    if (!alphabet_usable()) return;
    mag   = value[rsym_pkg::MAG_W-1] ? (32'd0 - value) : value;
    count = 0;
    do begin
      digits[count] = 4'(mag % base_len);
      mag           = mag / base_len;
      count++;
    end while (mag != 0 && count < 32);
    if (value[rsym_pkg::MAG_W-1]) begin
      owed_symbols.push_back('{symbol: rsym_pkg::SYM_MINUS, last: 1'b0});
    end
    for (int k = count - 1; k >= 0; k--) begin
      owed_symbols.push_back('{symbol: alpha_byte(digits[k]), last: (k == 0)});
    end
  endfunction

  // Every accepted output item is checked against the oldest prediction.
  always @(posedge clk) begin : compare_symbols
    sym_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_symbols.size() == 0) begin
        $error("unexpected output item: symbol %02h last %0b", symbol, last);
        fail_count++;
      end else begin
        want = owed_symbols.pop_front();
        symbols_checked++;
        if (symbol !== want.symbol) begin
          $error("symbol: expected %02h, actual %02h", want.symbol, symbol);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last);
          fail_count++;
        end
      end
    end
  end

  // Writes all three registers in consecutive cycles, optionally followed by
  // a write to the unused index. The write enable stays high across the
  // burst and drops once at the end.
  task automatic program_alphabet(input logic [rsym_pkg::CFG_W-1:0] lo,
                                  input logic [rsym_pkg::CFG_W-1:0] hi,
                                  input logic [rsym_pkg::BASE_W-1:0] base,
                                  input bit poke_spare);
    cfg_write <= 1'b1;
    cfg_index <= rsym_pkg::REG_ALPHA_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= rsym_pkg::REG_ALPHA_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= rsym_pkg::REG_BASE_LEN;
    cfg_data  <= {{(rsym_pkg::CFG_W-rsym_pkg::BASE_W){1'b0}}, base};
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_data  <= {$urandom(), $urandom()};
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    alpha_lo = lo;
    alpha_hi = hi;
    base_len = base;
    settings_used++;
  endtask

  // Offers one number and returns once it is accepted. Valid is left high
  // so the next item can follow in the very next cycle; it is lowered only
  // when the sender decides to idle, or by settle. Idle gaps are mostly
  // short, with some long enough to land on any phase of a conversion.
  task automatic send_number(input logic [rsym_pkg::MAG_W-1:0] value);
    int gap;
    if (!calm && $urandom_range(99) < 18) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    number   <= value;
    do @(posedge clk); while (in_stall);
    predict_symbols(value);
    numbers_sent++;
  endtask

  // Stops offering items, waits for every predicted symbol, then gives the
  // block time to finish any item that produces nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (owed_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sixteen distinct random bytes, none of them a sign character.
  task automatic pick_alphabet(output logic [rsym_pkg::CFG_W-1:0] lo,
                               output logic [rsym_pkg::CFG_W-1:0] hi);
    bit                         taken [256];
    logic [rsym_pkg::SYM_W-1:0] b;
    logic [127:0]               both;
    for (int i = 0; i < 256; i++) taken[i] = 1'b0;
    for (int i = 0; i < 16; i++) begin
      do b = rsym_pkg::SYM_W'($urandom_range(255));
      while (taken[b] || b == rsym_pkg::SYM_PLUS || b == rsym_pkg::SYM_MINUS);
      taken[b]        = 1'b1;
      both[i*8 +: 8]  = b;
    end
    lo = both[63:0];
    hi = both[127:64];
  endtask

  // A mix of full-range values, shortened magnitudes of both signs, powers
  // of the radix and their neighbors, the extremes, and small values.
  function automatic logic [rsym_pkg::MAG_W-1:0] pick_number();
    logic [rsym_pkg::MAG_W-1:0] r;
    logic [rsym_pkg::MAG_W-1:0] p;
    r = $urandom();
    case ($urandom_range(7))
      0, 1, 2: return r;
      3: return r >> $urandom_range(31);
      4: return 32'd0 - (r >> $urandom_range(31));
      5: begin
        if (base_len < rsym_pkg::MIN_BASE) return r;
        p = 1;
        repeat ($urandom_range(31)) begin
          if (p <= 32'hFFFF_FFFF / base_len) p = p * base_len;
        end
        p = p + $urandom_range(2) - 1;
        return $urandom_range(1) ? (32'd0 - p) : p;
      end
      6: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom_range(600) - 300;
    endcase
  endfunction

  // After reset the length is zero, so nothing may come out.
  task automatic check_reset_alphabet();
    send_number(32'd0);
    send_number(32'h8000_0000);
    settle();
  endtask

  // Plain decimal digits, run without idling. A write to the unused index
  // is slipped in after the real registers and must change nothing.
  task automatic check_decimal();
    calm = 1'b1;
    program_alphabet("76543210", 64'h3938, 5'd10, 1'b1);
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'hFFFF_FFFF);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'd1000000000);
    send_number(32'd0 - 32'd10);
    settle();
    calm = 1'b0;
  endtask

  // Radix 2 gives the longest runs: the most negative number yields a minus
  // and 32 digits. The symbols are 0x00 and 0xFF; the unused bytes hold
  // repeats and sign characters, which must not make the alphabet invalid.
  task automatic check_binary_extremes();
    program_alphabet(64'h2D2B_2B00_0000_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2, 1'b0);
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number(32'hFFFF_FFFF);
    send_number(32'h5555_5555);
    send_number(32'hAAAA_AAAA);
    settle();
  endtask

  // The largest radix uses every byte of both words.
  task automatic check_hex();
    program_alphabet(64'h7766_5544_3322_1100, 64'hFFEE_DDCC_BBAA_9988, 5'd16, 1'b0);
    send_number(32'h8000_0000);
    send_number(32'h0123_4567);
    send_number(32'hFEDC_BA98);
    settle();
    // Radix 5 with sign characters just past the symbols in use is valid.
    program_alphabet("7-+43210", "fedcba98", 5'd5, 1'b0);
    send_number(32'd0 - 32'd124);
    settle();
  endtask

  // Each broken alphabet must swallow its item without a result.
  task automatic check_bad_alphabets();
    program_alphabet("76543210", "fedcba98", 5'd1, 1'b0);
    send_number(32'd7);
    settle();
    program_alphabet("76543210", "fedcba98", 5'd17, 1'b0);
    send_number(32'd0 - 32'd7);
    settle();
    program_alphabet("76543210", "fedcba98", 5'd31, 1'b0);
    send_number(32'd12345);
    settle();
    // The last symbol in use repeats the first.
    program_alphabet("76543210", "0edcba98", 5'd16, 1'b0);
    send_number(32'h8000_0000);
    settle();
    program_alphabet("765+3210", 64'h3938, 5'd10, 1'b0);
    send_number(32'd99);
    settle();
    program_alphabet("76543210", "fedcba-8", 5'd16, 1'b0);
    send_number(32'h7FFF_FFFF);
    settle();
  endtask

  // Ten phases of random numbers, each with a fresh random alphabet. The
  // first runs without idling; the radix extremes get a phase each. One
  // extra short phase uses a randomly broken alphabet.
  task automatic check_random_phases();
    logic [rsym_pkg::CFG_W-1:0]  lo;
    logic [rsym_pkg::CFG_W-1:0]  hi;
    logic [rsym_pkg::BASE_W-1:0] base;
    logic [127:0]                both;
    int                          i;
    int                          j;
    for (int phase = 0; phase < 10; phase++) begin
      calm = (phase == 0);
      pick_alphabet(lo, hi);
      case (phase)
        1:       base = 5'd2;
        2:       base = 5'd16;
        default: base = rsym_pkg::BASE_W'($urandom_range(2, 16));
      endcase
      program_alphabet(lo, hi, base, 1'b0);
      repeat (30) send_number(pick_number());
      settle();
      if (phase == 5) begin
        pick_alphabet(lo, hi);
        base = rsym_pkg::BASE_W'($urandom_range(2, 16));
        both = {hi, lo};
        i    = $urandom_range(base - 2);
        j    = $urandom_range(i + 1, base - 1);
        case ($urandom_range(2))
          0:       both[j*8 +: 8] = both[i*8 +: 8];
          1:       both[i*8 +: 8] = rsym_pkg::SYM_PLUS;
          default: both[j*8 +: 8] = rsym_pkg::SYM_MINUS;
        endcase
        program_alphabet(both[63:0], both[127:64], base, 1'b0);
        repeat (4) send_number(pick_number());
        settle();
      end
    end
    calm = 1'b0;
  endtask

  // Guards against a hung handshake or a lost symbol.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $error("run timed out after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_reset_alphabet();
    check_decimal();
    check_binary_extremes();
    check_hex();
    check_bad_alphabets();
    check_random_phases();
    $display("Converted %0d numbers under %0d alphabet settings; %0d symbols checked.",
             numbers_sent, settings_used, symbols_checked);
    $display("Radixes 2 to 16, rejected alphabets, zero and both extremes were exercised.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[signed_integer_to_radix_symbols_top.f]
hdl/rsym_pkg.sv
hdl/rsym_cell.sv
hdl/rsym_alpha_check.sv
hdl/signed_integer_to_radix_symbols_top.sv
tb/tb_signed_integer_to_radix_symbols_top.sv
